// File: rtl/tsec_pkg.sv
// Package for the touch segment envelope capture block.
// Types, constants and command/status structs shared by the controller,
// the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsec_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHANNELS = 4;
  localparam int SUM_W = 18;
  localparam int CNT_W = 16;
  localparam int CFG_W = 18;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW_ROWS_DEF = 16;
  localparam int SEGMENT_ROWS_DEF = 8;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [SUM_W-1:0] TOUCH_THR_RST = SUM_W'(2048);
  localparam logic [SUM_W-1:0] ENV_THR_RST = SUM_W'(512);
  localparam logic PREDICT_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREDICT = 2'd2;

  typedef enum logic [1:0] {
    ENV_NONE    = 2'd0,
    ENV_SUSTAIN = 2'd1,
    ENV_ATTACK  = 2'd2,
    ENV_RELEASE = 2'd3
  } env_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWSUM,
    ST_TOTAL,
    ST_EVAL,
    ST_SINGLE,
    ST_SEG_READ,
    ST_SEG_EMIT
  } state_e;

  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch0;
  } in_item_t;

  typedef struct packed {
    logic                touch_flag;
    logic [1:0]          envelope;
    logic [CNT_W-1:0]    touch_ticks;
    logic [CNT_W-1:0]    segments_done;
    logic                row_valid;
    logic [SAMPLE_W-1:0] row_ch0;
    logic [SAMPLE_W-1:0] row_ch1;
    logic [SAMPLE_W-1:0] row_ch2;
    logic [SAMPLE_W-1:0] row_ch3;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] touch_thr;
    logic [SUM_W-1:0] env_thr;
    logic             predict;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic row_sum;
    logic total_upd;
    logic eval;
    logic load_single;
    logic seg_rd;
    logic load_row;
  } cmd_t;

  typedef struct packed {
    logic dump;
    logic out_free;
    logic last_row;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/tsec_ctrl.sv
// Controller state machine for the touch segment envelope capture block.
// Sequences one frame through the datapath and the dump of the segment store.
// Depends on tsec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsec_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tsec_pkg::status_t status_i,
  output tsec_pkg::cmd_t         cmd_o
);

  tsec_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsec_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tsec_pkg::ST_ROWSUM;
      end
      tsec_pkg::ST_ROWSUM: state_d = tsec_pkg::ST_TOTAL;
      tsec_pkg::ST_TOTAL:  state_d = tsec_pkg::ST_EVAL;
      tsec_pkg::ST_EVAL: begin
        state_d = status_i.dump ? tsec_pkg::ST_SEG_READ : tsec_pkg::ST_SINGLE;
      end
      tsec_pkg::ST_SINGLE: begin
        if (status_i.out_free) state_d = tsec_pkg::ST_IDLE;
      end
      tsec_pkg::ST_SEG_READ: state_d = tsec_pkg::ST_SEG_EMIT;
      tsec_pkg::ST_SEG_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_row ? tsec_pkg::ST_IDLE : tsec_pkg::ST_SEG_READ;
        end
      end
      default: state_d = tsec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tsec_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tsec_pkg::ST_ROWSUM:   cmd_o.row_sum = 1'b1;
      tsec_pkg::ST_TOTAL:    cmd_o.total_upd = 1'b1;
      tsec_pkg::ST_EVAL:     cmd_o.eval = 1'b1;
      tsec_pkg::ST_SINGLE:   cmd_o.load_single = status_i.out_free;
      tsec_pkg::ST_SEG_READ: cmd_o.seg_rd = 1'b1;
      tsec_pkg::ST_SEG_EMIT: cmd_o.load_row = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && state_q == tsec_pkg::ST_ROWSUM))
    else $error("transfer accepted but frame not started");

endmodule

`default_nettype wire

// File: rtl/tsec_datapath.sv
// Datapath for the touch segment envelope capture block: ring window with
// running sum, envelope evaluation, segment store and output register.
// Depends on tsec_pkg; driven by tsec_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module tsec_datapath #(
  parameter int WINDOW_ROWS  = tsec_pkg::WINDOW_ROWS_DEF,
  parameter int SEGMENT_ROWS = tsec_pkg::SEGMENT_ROWS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tsec_pkg::cfg_t     cfg_i,
  input  wire tsec_pkg::in_item_t in_data_i,
  input  wire tsec_pkg::cmd_t     cmd_i,
  output tsec_pkg::status_t       status_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tsec_pkg::out_item_t     out_data_o
);

  localparam int SW        = tsec_pkg::SAMPLE_W;
  localparam int CH        = tsec_pkg::CHANNELS;
  localparam int SUM_W     = tsec_pkg::SUM_W;
  localparam int CNT_W     = tsec_pkg::CNT_W;
  localparam int WIN_AW    = $clog2(WINDOW_ROWS);
  localparam int SEG_AW    = $clog2(SEGMENT_ROWS);
  localparam int ROWSUM_W  = SW + $clog2(CH);
  localparam int TOT_RAW_W = SW + $clog2(WINDOW_ROWS * CH);
  localparam int TOT_W     = (TOT_RAW_W > SUM_W) ? TOT_RAW_W : SUM_W;

  localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_ROWS - 1);
  localparam logic [SEG_AW-1:0] SEG_LAST = SEG_AW'(SEGMENT_ROWS - 1);

  // Window store
  tsec_pkg::row_t            win_mem [WINDOW_ROWS];
  logic [WINDOW_ROWS-1:0]    win_vld_q;
  logic [WIN_AW-1:0]         ptr_q;
  tsec_pkg::row_t            win_rd_q;
  logic                      win_rd_vld_q;
  tsec_pkg::row_t            frame_q;

  logic [ROWSUM_W-1:0]       new_rs, old_rs, new_rs_q, old_rs_q;
  logic [TOT_W-1:0]          total_q, total_d;
  logic [SUM_W-1:0]          win_sum_q, prev_sum_q;

  // Segment store
  tsec_pkg::row_t            seg_mem [SEGMENT_ROWS];
  logic [SEGMENT_ROWS-1:0]   seg_vld_q;
  logic [SEG_AW-1:0]         seg_row_q;
  logic [SEG_AW-1:0]         dump_idx_q;
  tsec_pkg::row_t            seg_rd_q;
  logic                      seg_rd_vld_q;

  logic [CNT_W-1:0]          tick_q, seg_cnt_q, ticks_out_q;
  tsec_pkg::env_e            env_q, env_d;
  logic                      dump_q, flag_q;

  // Evaluation
  logic                      active, start, pos, neg, half, full, env_dump, ended, dump;
  logic [SUM_W-1:0]          mag;
  logic [CNT_W-1:0]          tick_inc;
  logic [SEG_AW-1:0]         row_cur;

  tsec_pkg::out_item_t       out_q, out_d;
  logic                      out_valid_q;
  tsec_pkg::row_t            dump_row;

  always_comb begin
    new_rs = '0;
    old_rs = '0;
    for (int c = 0; c < CH; c++) begin
      new_rs = new_rs + ROWSUM_W'(frame_q[c]);
      old_rs = old_rs + (win_rd_vld_q ? ROWSUM_W'(win_rd_q[c]) : '0);
    end
  end

  assign total_d = total_q - TOT_W'(old_rs_q) + TOT_W'(new_rs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      frame_q  <= tsec_pkg::row_t'(in_data_i);
      win_rd_q <= win_mem[ptr_q];
    end
    if (cmd_i.total_upd) win_mem[ptr_q] <= frame_q;
    if (cmd_i.row_sum) begin
      new_rs_q <= new_rs;
      old_rs_q <= old_rs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q    <= '0;
      win_rd_vld_q <= 1'b0;
      ptr_q        <= '0;
      total_q      <= '0;
      win_sum_q    <= '0;
    end else begin
      if (cmd_i.accept) win_rd_vld_q <= win_vld_q[ptr_q];
      if (cmd_i.total_upd) begin
        win_vld_q[ptr_q] <= 1'b1;
        ptr_q            <= (ptr_q == WIN_LAST) ? '0 : ptr_q + 1'b1;
        total_q          <= total_d;
        win_sum_q        <= (total_d > TOT_W'(tsec_pkg::SUM_MAX)) ?
                            tsec_pkg::SUM_MAX : total_d[SUM_W-1:0];
      end
    end
  end

  always_comb begin
    active   = (tick_q != '0) || (win_sum_q > cfg_i.touch_thr);
    start    = active && (tick_q == '0);
    pos      = win_sum_q > prev_sum_q;
    neg      = win_sum_q < prev_sum_q;
    mag      = pos ? (win_sum_q - prev_sum_q) : (prev_sum_q - win_sum_q);
    if (!active) begin
      env_d = tsec_pkg::ENV_NONE;
    end else if (mag < cfg_i.env_thr) begin
      env_d = tsec_pkg::ENV_SUSTAIN;
    end else if (pos) begin
      env_d = tsec_pkg::ENV_ATTACK;
    end else if (neg) begin
      env_d = tsec_pkg::ENV_RELEASE;
    end else begin
      env_d = env_q;
    end
    tick_inc = (tick_q != tsec_pkg::CNT_MAX) ? tick_q + 1'b1 : tick_q;
    row_cur  = start ? '0 : seg_row_q;
    half     = {win_sum_q, 1'b0} < {1'b0, cfg_i.touch_thr};
    full     = row_cur == SEG_LAST;
    env_dump = (env_d != env_q) && (env_q != tsec_pkg::ENV_NONE) &&
               (env_d != tsec_pkg::ENV_NONE) && cfg_i.predict;
    ended    = active && (half || full);
    dump     = active && (half || full || env_dump);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && active) seg_mem[row_cur] <= frame_q;
    if (cmd_i.seg_rd) seg_rd_q <= seg_mem[dump_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q    <= '0;
      seg_rd_vld_q <= 1'b0;
      seg_row_q    <= '0;
      dump_idx_q   <= '0;
      tick_q       <= '0;
      seg_cnt_q    <= '0;
      ticks_out_q  <= '0;
      prev_sum_q   <= '0;
      env_q        <= tsec_pkg::ENV_NONE;
      dump_q       <= 1'b0;
      flag_q       <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        env_q       <= env_d;
        prev_sum_q  <= win_sum_q;
        dump_q      <= dump;
        flag_q      <= dump && cfg_i.predict;
        ticks_out_q <= active ? tick_inc : '0;
        dump_idx_q  <= '0;
        if (active) begin
          if (start) begin
            seg_vld_q <= SEGMENT_ROWS'(1'b1);
          end else begin
            seg_vld_q[row_cur] <= 1'b1;
          end
          tick_q    <= ended ? '0 : tick_inc;
          seg_row_q <= ended ? '0 : row_cur + 1'b1;
        end
        if (ended && seg_cnt_q != tsec_pkg::CNT_MAX) seg_cnt_q <= seg_cnt_q + 1'b1;
      end
      if (cmd_i.seg_rd) seg_rd_vld_q <= seg_vld_q[dump_idx_q];
      if (cmd_i.load_row) dump_idx_q <= (dump_idx_q == SEG_LAST) ? '0 : dump_idx_q + 1'b1;
    end
  end

  assign dump_row = seg_rd_vld_q ? seg_rd_q : '0;

  always_comb begin
    out_d               = '0;
    out_d.touch_flag    = flag_q;
    out_d.envelope      = env_q;
    out_d.touch_ticks   = ticks_out_q;
    out_d.segments_done = seg_cnt_q;
    out_d.last          = cmd_i.load_single || (dump_idx_q == SEG_LAST);
    if (cmd_i.load_row) begin
      out_d.row_valid = dump_q;
      out_d.row_ch0   = dump_row[0];
      out_d.row_ch1   = dump_row[1];
      out_d.row_ch2   = dump_row[2];
      out_d.row_ch3   = dump_row[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single || cmd_i.load_row) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_row) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.dump     = dump;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_row = dump_idx_q == SEG_LAST;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_single || cmd_i.load_row) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= WIN_LAST)
    else $error("window pointer out of range");

  a_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q == '0) |-> (seg_row_q == '0))
    else $error("segment row set with no open segment");

endmodule

`default_nettype wire

// File: rtl/touch_segment_envelope_capture_core.sv
// A frame without a dump goes through ROWSUM, TOTAL and EVAL, then SINGLE loads its
// result into the output register once it is free; no new frame is taken until IDLE.
// A dumping frame gives SEGMENT_ROWS results, each one a segment store read followed
// by an output load that waits until the output register is free.
// Reset: registers to defaults, window and segment store cleared at once via
// per-row valid bits, no clearing pass. Depends on tsec_pkg, tsec_ctrl, tsec_datapath.
`timescale 1ns / 1ps
`default_nettype none

module touch_segment_envelope_capture_core #(
  parameter int WINDOW_ROWS  = tsec_pkg::WINDOW_ROWS_DEF,
  parameter int SEGMENT_ROWS = tsec_pkg::SEGMENT_ROWS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire tsec_pkg::in_item_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output tsec_pkg::out_item_t                     out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tsec_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tsec_pkg::CFG_W-1:0]         cfg_wdata_i
);

  tsec_pkg::cfg_t    cfg_q;
  tsec_pkg::cmd_t    cmd;
  tsec_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_thr <= tsec_pkg::TOUCH_THR_RST;
      cfg_q.env_thr   <= tsec_pkg::ENV_THR_RST;
      cfg_q.predict   <= tsec_pkg::PREDICT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsec_pkg::CFG_TOUCH_THR: cfg_q.touch_thr <= cfg_wdata_i[tsec_pkg::SUM_W-1:0];
        tsec_pkg::CFG_ENV_THR:   cfg_q.env_thr <= cfg_wdata_i[tsec_pkg::SUM_W-1:0];
        tsec_pkg::CFG_PREDICT:   cfg_q.predict <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tsec_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tsec_datapath #(
    .WINDOW_ROWS (WINDOW_ROWS),
    .SEGMENT_ROWS(SEGMENT_ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: verif/tb_touch_segment_envelope_capture_core.sv
// Testbench for touch_segment_envelope_capture_core: frames go in through a queue-fed
// driver, an in-bench envelope/segment predictor builds the expected rows, a monitor
// checks every result transfer. Depends on tsec_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_touch_segment_envelope_capture_core;
  import tsec_pkg::*;

  localparam int WIN_ROWS = WINDOW_ROWS_DEF;
  localparam int SEG_ROWS = SEGMENT_ROWS_DEF;
  localparam int SETTLE = 4 + 2 * SEG_ROWS + 10;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_TOUCH_THR;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  touch_segment_envelope_capture_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and register copy
  logic [SAMPLE_W-1:0] win_mem [WIN_ROWS][CHANNELS];
  logic [SAMPLE_W-1:0] seg_mem [SEG_ROWS][CHANNELS];
  int win_ptr;
  int seg_fill;
  logic [SUM_W-1:0] prev_total;
  logic [CNT_W-1:0] ticks;
  logic [CNT_W-1:0] seg_done;
  env_e env_now;
  logic [SUM_W-1:0] thr_touch;
  logic [SUM_W-1:0] thr_env;
  logic pred_on;

  in_item_t frames_pending[$];
  out_item_t rows_due[$];
  int frames_queued = 0;
  int frames_taken = 0;
  int fails = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;
  int hold_cnt = 0;
  int tx_gap = 0;
  int rx_gap = 0;

  task automatic capture_frame(input in_item_t f);
    logic [SAMPLE_W-1:0] smp [CHANNELS];
    int unsigned total;
    logic [SUM_W-1:0] wsum;
    int delta;
    int unsigned mag;
    bit active;
    bit dump;
    bit ended;
    env_e env_prev;
    logic [CNT_W-1:0] ticks_out;
    out_item_t r;
    int n;
    int i;
    int j;
    smp[0] = f.sample_ch0;
    smp[1] = f.sample_ch1;
    smp[2] = f.sample_ch2;
    smp[3] = f.sample_ch3;
    dump = 1'b0;
    ended = 1'b0;
    ticks_out = '0;
    total = 0;
    for (j = 0; j < CHANNELS; j++) win_mem[win_ptr][j] = smp[j];
    win_ptr = (win_ptr == WIN_ROWS - 1) ? 0 : win_ptr + 1;
    for (i = 0; i < WIN_ROWS; i++)
      for (j = 0; j < CHANNELS; j++) total += win_mem[i][j];
    wsum = (total > int'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
    delta = int'(wsum) - int'(prev_total);
    prev_total = wsum;
    active = (ticks != 0) || (wsum > thr_touch);
    env_prev = env_now;
    mag = (delta < 0) ? -delta : delta;
    if (!active) begin
      env_now = ENV_NONE;
    end else if (mag < thr_env) begin
      env_now = ENV_SUSTAIN;
    end else if (delta > 0) begin
      env_now = ENV_ATTACK;
    end else if (delta < 0) begin
      env_now = ENV_RELEASE;
    end
    if (active) begin
      if (ticks == 0) begin
        for (i = 0; i < SEG_ROWS; i++)
          for (j = 0; j < CHANNELS; j++) seg_mem[i][j] = '0;
        seg_fill = 0;
      end
      if (ticks != CNT_MAX) ticks = ticks + 1'b1;
      ticks_out = ticks;
      if (seg_fill >= SEG_ROWS) seg_fill = SEG_ROWS - 1;
      for (j = 0; j < CHANNELS; j++) seg_mem[seg_fill][j] = smp[j];
      seg_fill++;
      if (2 * int'(wsum) < int'(thr_touch)) begin
        seg_fill = SEG_ROWS;
      end else if (env_now != env_prev && env_prev != ENV_NONE && env_now != ENV_NONE &&
                   pred_on) begin
        dump = 1'b1;
      end
      if (seg_fill >= SEG_ROWS) begin
        dump = 1'b1;
        ended = 1'b1;
      end
    end
    if (ended) begin
      if (seg_done != CNT_MAX) seg_done = seg_done + 1'b1;
      ticks = '0;
      seg_fill = 0;
    end
    n = dump ? SEG_ROWS : 1;
    for (i = 0; i < n; i++) begin
      r = '0;
      r.touch_flag = dump && pred_on;
      r.envelope = env_now;
      r.touch_ticks = ticks_out;
      r.segments_done = seg_done;
      r.row_valid = dump;
      if (dump) begin
        r.row_ch0 = seg_mem[i][0];
        r.row_ch1 = seg_mem[i][1];
        r.row_ch2 = seg_mem[i][2];
        r.row_ch3 = seg_mem[i][3];
      end
      r.last = (i == n - 1);
      rows_due.push_back(r);
    end
  endtask

  function automatic string show(input out_item_t r);
    return $sformatf("flag=%0d env=%0d ticks=%0d segs=%0d rv=%0d row=%03h/%03h/%03h/%03h last=%0d",
                     r.touch_flag, r.envelope, r.touch_ticks, r.segments_done, r.row_valid,
                     r.row_ch0, r.row_ch1, r.row_ch2, r.row_ch3, r.last);
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  // sender: transfer frames from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        capture_frame(in_data_i);
        frames_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (frames_pending.size() != 0) begin
          in_data_i <= frames_pending.pop_front();
          in_valid_i <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    out_item_t exp_row;
    string diff;
    if (rst_ni) begin
      if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_gap <= $urandom_range(1, 10);
      end
      out_ready_i <= (rx_gap == 0) && (hold_cnt == 0);
      if (out_valid_o && out_ready_i) begin
        if (rows_due.size() == 0) begin
          note_fail($sformatf("unexpected result: %s", show(out_data_o)));
        end else begin
          exp_row = rows_due.pop_front();
          diff = "";
          if (out_data_o.touch_flag !== exp_row.touch_flag) diff = {diff, " touch_flag"};
          if (out_data_o.envelope !== exp_row.envelope) diff = {diff, " envelope"};
          if (out_data_o.touch_ticks !== exp_row.touch_ticks) diff = {diff, " touch_ticks"};
          if (out_data_o.segments_done !== exp_row.segments_done)
            diff = {diff, " segments_done"};
          if (out_data_o.row_valid !== exp_row.row_valid) diff = {diff, " row_valid"};
          if (out_data_o.row_ch0 !== exp_row.row_ch0) diff = {diff, " row_ch0"};
          if (out_data_o.row_ch1 !== exp_row.row_ch1) diff = {diff, " row_ch1"};
          if (out_data_o.row_ch2 !== exp_row.row_ch2) diff = {diff, " row_ch2"};
          if (out_data_o.row_ch3 !== exp_row.row_ch3) diff = {diff, " row_ch3"};
          if (out_data_o.last !== exp_row.last) diff = {diff, " last"};
          if (diff != "")
            note_fail($sformatf("mismatch%s\n  exp %s\n  got %s", diff, show(exp_row),
                                show(out_data_o)));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** touch_segment_envelope_capture_core: FAILED **");
      $finish;
    end
  end

  task automatic push_frame(input logic [11:0] a, input logic [11:0] b,
                            input logic [11:0] c, input logic [11:0] d);
    in_item_t f;
    f.sample_ch0 = a;
    f.sample_ch1 = b;
    f.sample_ch2 = c;
    f.sample_ch3 = d;
    frames_pending.push_back(f);
    frames_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TOUCH_THR: thr_touch = val;
      CFG_ENV_THR:   thr_env = val;
      CFG_PREDICT:   pred_on = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (frames_taken != frames_queued || rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // press: rise to a level, hold, release into quiet frames; otherwise noise
  task automatic queue_touch_stream(input int count);
    int added;
    int len;
    int lvl;
    int k;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 10);
        lvl = $urandom_range(100, 4095);
        for (k = 0; k < len && added < count; k++) begin
          push_frame(12'($urandom_range(lvl / 2, lvl)), 12'($urandom_range(lvl / 2, lvl)),
                     12'($urandom_range(lvl / 2, lvl)), 12'($urandom_range(lvl / 2, lvl)));
          added++;
        end
        len = $urandom_range(0, 16);
        for (k = 0; k < len && added < count; k++) begin
          push_frame(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)),
                     12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
          added++;
        end
      end else begin
        push_frame(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        added++;
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_level(input int hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SUM_MAX;
      default: return CFG_W'($urandom_range(0, hi));
    endcase
  endfunction

  initial begin
    int i;
    int j;
    int ph;
    for (i = 0; i < WIN_ROWS; i++)
      for (j = 0; j < CHANNELS; j++) win_mem[i][j] = '0;
    for (i = 0; i < SEG_ROWS; i++)
      for (j = 0; j < CHANNELS; j++) seg_mem[i][j] = '0;
    win_ptr = 0;
    seg_fill = 0;
    prev_total = '0;
    ticks = '0;
    seg_done = '0;
    env_now = ENV_NONE;
    thr_touch = TOUCH_THR_RST;
    thr_env = ENV_THR_RST;
    pred_on = PREDICT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes under reset settings
    push_frame(12'h000, 12'h000, 12'h000, 12'h000);
    push_frame(12'hfff, 12'hfff, 12'hfff, 12'hfff);
    push_frame(12'haaa, 12'h555, 12'haaa, 12'h555);
    push_frame(12'h555, 12'haaa, 12'h555, 12'haaa);
    push_frame(12'hfff, 12'h000, 12'h000, 12'h000);
    push_frame(12'h000, 12'h000, 12'h000, 12'h000);
    push_frame(12'h000, 12'h000, 12'h000, 12'h000);
    push_frame(12'h000, 12'h000, 12'h000, 12'h000);
    push_frame(12'h000, 12'h000, 12'h000, 12'hfff);
    push_frame(12'h001, 12'h002, 12'h003, 12'h004);
    drain();

    // zero threshold, zero change holds the envelope, no prediction dumps
    write_reg(CFG_TOUCH_THR, '0);
    write_reg(CFG_ENV_THR, '0);
    write_reg(CFG_PREDICT, {17'($urandom_range(0, 131071)), 1'b0});
    repeat (6) push_frame(12'h000, 12'h000, 12'h000, 12'h000);
    drain();
    if (ticks == 0) begin
      push_frame(12'h100, 12'h000, 12'h000, 12'h000);
      drain();
    end

    // open segment falls under half of a maximal threshold
    write_reg(CFG_TOUCH_THR, SUM_MAX);
    write_reg(CFG_ENV_THR, SUM_MAX);
    write_reg(CFG_PREDICT, {17'($urandom_range(0, 131071)), 1'b1});
    push_frame(12'h7ff, 12'h800, 12'h0f0, 12'hf0f);
    push_frame(12'h000, 12'hfff, 12'h000, 12'hfff);
    push_frame(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    push_frame(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TOUCH_THR, pick_level(60000));
      write_reg(CFG_ENV_THR, pick_level(6000));
      write_reg(CFG_PREDICT, {17'($urandom_range(0, 131071)),
                              (ph == 4) ? 1'b0 : (ph == 5) ? 1'b1 : 1'($urandom_range(0, 1))});
      idle_on = (ph != 5);
      if (ph == 0) hold_req = ~hold_req;
      queue_touch_stream(55);
      drain();
    end

    fails += rows_due.size();
    if (fails == 0) begin
      $display("** touch_segment_envelope_capture_core: PASSED **");
    end else begin
      $display("** touch_segment_envelope_capture_core: FAILED **");
    end
    $finish;
  end

endmodule
